// ===== rtl/core/fba_pkg.sv =====
// Shared constants, codes and field widths of the frame bitmap allocator.
// No dependencies; the top level refers to it by scoped names, the testbench files import it.
`default_nettype none

package fba_pkg;

	// Default geometry of the occupancy map
	localparam int FRAME_COUNT = 16384;
	localparam int WORD_BITS   = 32;

	// Fixed field widths of the channels
	localparam int OP_W        = 2;
	localparam int FN_IN_W     = 16;
	localparam int STATUS_W    = 2;
	localparam int ALLOC_FN_W  = 14;
	localparam int ADDR_W      = 26;
	localparam int CFG_W       = 15;

	// Frames are 4 KiB, so the byte address is the frame number shifted by 12
	localparam int FRAME_SHIFT = 12;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_INIT  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/fba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/fba_word_scan.sv =====
// Lowest-free-bit search over one occupancy word.
// No dependencies; bits past the end of the map in the last word count as used.
`default_nettype none

module fba_word_scan #(
	parameter int WORD_BITS = 32,
	parameter int PAD_FROM  = 0,
	parameter int WB_LOG    = $clog2(WORD_BITS)
) (
	input  wire logic [WORD_BITS-1:0] word,
	input  wire logic                 is_last,
	output logic                      found,
	output logic [WB_LOG-1:0]         bit_idx
);

	localparam logic [WORD_BITS-1:0] ONES     = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] PAD_MASK = (PAD_FROM == 0) ? '0 : (ONES << PAD_FROM);

	logic [WORD_BITS-1:0] eff;

	always_comb begin
		eff     = is_last ? (word | PAD_MASK) : word;
		found   = ~&eff;
		bit_idx = '0;
		// walk down so the lowest clear bit wins
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!eff[i]) begin
				bit_idx = WB_LOG'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/frame_bitmap_allocator_top.sv =====
// Top level of the first-fit physical frame allocator.
// Depends on fba_pkg, fba_ram and fba_word_scan.
`default_nettype none

// Usage
// - Input channel (in_valid / in_stall, op, frame_number): one beat is one
//   command: allocate, free, init, or no-op. A beat is taken when in_valid is
//   high and in_stall is low; in_stall is high while a command is in work.
// - Output channel (out_valid / out_stall, status, alloc_frame_number,
//   alloc_address): exactly one result beat per command, held stable while
//   out_stall is high. The result sits in an output register, so the next
//   command is accepted while that beat is still waiting.
// - Config channel (cfg_valid / cfg_ready, cfg_data): writes reserved_frames;
//   cfg_ready is always high. Write it only while no command is in flight.
// Steps of each command, with the map held in one word-wide RAM read once per
// cycle; the result is registered before it is handed over:
// - allocate: reads words from word 0 upward until one has a clear bit (at
//   most WORD_COUNT, 512 with the default map), sets it and writes it back;
// - free: read, then modify and write back; out-of-range free or no-op: no
//   map access; init: WORD_COUNT words written, one word written per cycle.
// A finished result waits in place while the receiver stalls and the output
// register is still full, so the map write of that command is held with it.
// After reset the map is swept to zero, one word per cycle, over all WORD_COUNT
// words (512 by default); no command is accepted during the sweep.
module frame_bitmap_allocator_top #(
	parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT,
	parameter int WORD_BITS   = fba_pkg::WORD_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [fba_pkg::OP_W-1:0]      op,
	input  wire logic [fba_pkg::FN_IN_W-1:0]   frame_number,
	// result channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [fba_pkg::STATUS_W-1:0]       status,
	output logic [fba_pkg::ALLOC_FN_W-1:0]     alloc_frame_number,
	output logic [fba_pkg::ADDR_W-1:0]         alloc_address,
	// reserved_frames write
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [fba_pkg::CFG_W-1:0]     cfg_data
);

	localparam int WB_LOG     = $clog2(WORD_BITS);
	localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int CNT_W      = $clog2(FRAME_COUNT + 1);
	localparam int CFG_W      = fba_pkg::CFG_W;
	localparam int FN_IN_W    = fba_pkg::FN_IN_W;
	localparam int FN_OUT_W   = fba_pkg::ALLOC_FN_W;
	localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int RNG_W      = (CNT_W > FN_IN_W) ? CNT_W : FN_IN_W;
	localparam int PAD_FROM   = FRAME_COUNT % WORD_BITS;

	localparam logic [AW-1:0]        LAST_IDX = AW'(WORD_COUNT - 1);
	localparam logic [CMP_W-1:0]     FC_CMP   = CMP_W'(FRAME_COUNT);
	localparam logic [RNG_W-1:0]     FC_RNG   = RNG_W'(FRAME_COUNT);
	localparam logic [WORD_BITS-1:0] ONES     = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] ONE      = WORD_BITS'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FREE_RD,
		ST_SWEEP,
		ST_WRITE
	} state_t;

	state_t                   state_q;
	logic [AW-1:0]            idx_q;        // word being read or swept
	logic [WB_LOG-1:0]        bit_q;        // bit to clear on free
	logic [WORD_BITS-1:0]     wdata_q;      // word to write back
	logic                     wr_q;         // write-back pending with the result
	logic                     init_q;       // sweep belongs to an init command
	logic [CNT_W-1:0]         sweep_n_q;    // frames to mark used in the sweep
	logic [CFG_W-1:0]         reserved_q;
	fba_pkg::status_t         res_status_q;
	logic [FN_OUT_W-1:0]      res_fn_q;
	logic                     out_valid_q;
	fba_pkg::status_t         status_q;
	logic [FN_OUT_W-1:0]      alloc_fn_q;

	logic                     in_accept;
	logic                     out_free;
	fba_pkg::op_t             op_code;
	logic                     free_ok;
	logic [AW-1:0]            free_idx;
	logic [WB_LOG-1:0]        free_bit;
	logic [CNT_W-1:0]         sat_n;
	logic [CNT_W-1:0]         n_hi;
	logic [CNT_W-1:0]         idx_ext;
	logic [WORD_BITS-1:0]     sweep_word;
	logic                     is_last;
	logic                     found;
	logic [WB_LOG-1:0]        scan_bit;

	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic [WORD_BITS-1:0]     rd_data;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [WORD_BITS-1:0]     wr_data;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign op_code   = fba_pkg::op_t'(op);

	// free decode: word index and bit position of the frame
	assign free_ok  = RNG_W'(frame_number) < FC_RNG;
	assign free_idx = AW'(frame_number >> WB_LOG);
	assign free_bit = frame_number[WB_LOG-1:0];

	// clamp the reservation to the size of the map
	assign sat_n = (CMP_W'(reserved_q) > FC_CMP) ? CNT_W'(FRAME_COUNT) : CNT_W'(reserved_q);

	// sweep pattern: full words below the reservation edge, a partial word on
	// the edge, empty words above it
	assign n_hi    = sweep_n_q >> WB_LOG;
	assign idx_ext = CNT_W'(idx_q);
	always_comb begin
		if (idx_ext < n_hi) begin
			sweep_word = ONES;
		end else if (idx_ext == n_hi) begin
			sweep_word = ~(ONES << sweep_n_q[WB_LOG-1:0]);
		end else begin
			sweep_word = '0;
		end
	end

	assign is_last = (idx_q == LAST_IDX);

	fba_word_scan #(
		.WORD_BITS (WORD_BITS),
		.PAD_FROM  (PAD_FROM),
		.WB_LOG    (WB_LOG)
	) u_scan (
		.word    (rd_data),
		.is_last (is_last),
		.found   (found),
		.bit_idx (scan_bit)
	);

	fba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT),
		.AW    (AW)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// RAM port control; reads and writes never fall in the same cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = sweep_word;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept && op_code == fba_pkg::OP_ALLOC) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end else if (in_accept && op_code == fba_pkg::OP_FREE && free_ok) begin
					rd_en   = 1'b1;
					rd_addr = free_idx;
				end
			end
			ST_SCAN: begin
				// keep one read in flight per cycle until a free bit turns up or the last word is read
				if (!found && !is_last) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + 1'b1;
				end
			end
			ST_FREE_RD: begin
				rd_en = 1'b0;
			end
			ST_SWEEP: begin
				wr_en = 1'b1;
			end
			ST_WRITE: begin
				// hold the write-back until the result can be handed over
				wr_en   = wr_q && out_free;
				wr_data = wdata_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			idx_q       <= '0;
			sweep_n_q   <= '0;
			init_q      <= 1'b0;
			wr_q        <= 1'b0;
			reserved_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				reserved_q <= cfg_data;
			end
			// load a finished result, or drop the beat once the receiver takes it
			if (state_q == ST_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						unique case (op_code)
							fba_pkg::OP_ALLOC: begin
								idx_q   <= '0;
								state_q <= ST_SCAN;
							end
							fba_pkg::OP_FREE: begin
								if (free_ok) begin
									idx_q   <= free_idx;
									bit_q   <= free_bit;
									state_q <= ST_FREE_RD;
								end else begin
									res_status_q <= fba_pkg::STATUS_RANGE;
									res_fn_q     <= '0;
									wr_q         <= 1'b0;
									state_q      <= ST_WRITE;
								end
							end
							fba_pkg::OP_INIT: begin
								idx_q     <= '0;
								sweep_n_q <= sat_n;
								init_q    <= 1'b1;
								state_q   <= ST_SWEEP;
							end
							fba_pkg::OP_NOP: begin
								res_status_q <= fba_pkg::STATUS_DONE;
								res_fn_q     <= '0;
								wr_q         <= 1'b0;
								state_q      <= ST_WRITE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (found) begin
						wdata_q      <= rd_data | (ONE << scan_bit);
						res_status_q <= fba_pkg::STATUS_DONE;
						res_fn_q     <= FN_OUT_W'({idx_q, scan_bit});
						wr_q         <= 1'b1;
						state_q      <= ST_WRITE;
					end else if (is_last) begin
						// every frame in use: leave the map alone
						res_status_q <= fba_pkg::STATUS_FULL;
						res_fn_q     <= '0;
						wr_q         <= 1'b0;
						state_q      <= ST_WRITE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FREE_RD: begin
					wdata_q      <= rd_data & ~(ONE << bit_q);
					res_status_q <= fba_pkg::STATUS_DONE;
					res_fn_q     <= '0;
					wr_q         <= 1'b1;
					state_q      <= ST_WRITE;
				end
				ST_SWEEP: begin
					if (is_last) begin
						if (init_q) begin
							res_status_q <= fba_pkg::STATUS_DONE;
							res_fn_q     <= '0;
							wr_q         <= 1'b0;
							state_q      <= ST_WRITE;
						end else begin
							state_q <= ST_IDLE;
						end
						init_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						status_q    <= res_status_q;
						alloc_fn_q  <= res_fn_q;
						wr_q        <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign alloc_frame_number = alloc_fn_q;
	assign alloc_address      = {alloc_fn_q, {fba_pkg::FRAME_SHIFT{1'b0}}};

endmodule

`default_nettype wire

// ===== tb/sv/frame_bitmap_allocator_scoreboard.sv =====
// Scoreboard for the frame bitmap allocator: mirrors the occupancy map,
// predicts each result beat and compares it with what the block returns.
// Depends on fba_pkg for codes and field widths.
`timescale 1ns / 1ps

module frame_bitmap_allocator_scoreboard (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_stall,
	input  wire logic [fba_pkg::OP_W-1:0]      op,
	input  wire logic [fba_pkg::FN_IN_W-1:0]   frame_number,
	input  wire logic                          out_valid,
	input  wire logic                          out_stall,
	input  wire logic [fba_pkg::STATUS_W-1:0]  status,
	input  wire logic [fba_pkg::ALLOC_FN_W-1:0] alloc_frame_number,
	input  wire logic [fba_pkg::ADDR_W-1:0]    alloc_address,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [fba_pkg::CFG_W-1:0]     cfg_data,
	output int                                 mismatch_count,
	output int                                 outstanding
);
	import fba_pkg::*;

	localparam int MAP_WORDS    = FRAME_COUNT / WORD_BITS;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		status_t                 code;
		logic [ALLOC_FN_W-1:0]   frame;
		logic [ADDR_W-1:0]       addr;
	} alloc_result_t;

	logic [WORD_BITS-1:0] occ_map [MAP_WORDS];
	logic [CFG_W-1:0]     reserved_q;
	alloc_result_t        result_q [$];
	alloc_result_t        want;

	// Apply one command to the mirrored map and return its result beat
	function automatic alloc_result_t apply_command(op_t cmd, logic [FN_IN_W-1:0] fnum);
		alloc_result_t r;
		logic [WORD_BITS-1:0] ones;
		int w;
		int b;
		int n;
		int lo;
		bit found;
		r = '0;
		r.code = STATUS_DONE;
		ones = '1;
		found = 1'b0;
		case (cmd)
			OP_ALLOC: begin
				r.code = STATUS_FULL;
				for (w = 0; w < MAP_WORDS && !found; w++) begin
					if (occ_map[w] != ones) begin
						for (b = 0; b < WORD_BITS && !found; b++) begin
							if (!occ_map[w][b]) begin
								occ_map[w][b] = 1'b1;
								found = 1'b1;
								r.code = STATUS_DONE;
								r.frame = ALLOC_FN_W'(w * WORD_BITS + b);
								r.addr = ADDR_W'(r.frame) << FRAME_SHIFT;
							end
						end
					end
				end
			end
			OP_FREE: begin
				if (fnum >= FRAME_COUNT)
					r.code = STATUS_RANGE;
				else
					occ_map[fnum / WORD_BITS][fnum % WORD_BITS] = 1'b0;
			end
			OP_INIT: begin
				n = (reserved_q > FRAME_COUNT) ? FRAME_COUNT : int'(reserved_q);
				for (w = 0; w < MAP_WORDS; w++) begin
					lo = w * WORD_BITS;
					if (lo + WORD_BITS <= n)
						occ_map[w] = ones;
					else if (lo < n)
						occ_map[w] = ones >> (WORD_BITS - (n - lo));
					else
						occ_map[w] = '0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (occ_map[i])
				occ_map[i] = '0;
			reserved_q = '0;
			result_q.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result beat: status %0d frame %0d addr 0x%07h",
							status, alloc_frame_number, alloc_address);
				end else begin
					want = result_q.pop_front();
					if (want.code !== status || want.frame !== alloc_frame_number ||
							want.addr !== alloc_address) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display({"result mismatch: expected status %0d frame %0d ",
								"addr 0x%07h, got status %0d frame %0d addr 0x%07h"},
								want.code, want.frame, want.addr,
								status, alloc_frame_number, alloc_address);
					end
				end
			end
			if (in_valid && !in_stall)
				result_q.push_back(apply_command(op_t'(op), frame_number));
			if (cfg_valid && cfg_ready)
				reserved_q = cfg_data;
			outstanding = result_q.size();
		end
	end

endmodule

// ===== tb/sv/frame_bitmap_allocator_top_tb.sv =====
// Top of the frame bitmap allocator testbench: clock, reset, command and
// config stimulus, receiver stalls and the verdict.
// Depends on fba_pkg, frame_bitmap_allocator_top and the scoreboard module.
`timescale 1ns / 1ps

module frame_bitmap_allocator_top_tb;
	import fba_pkg::*;

	// Guard against a hung block; the slowest correct run is far below this
	localparam int CYCLE_LIMIT    = 3_000_000;
	localparam int PHASE_ITEMS    = 191;
	localparam int RX_HOLD_CYCLES = 3000;
	// Longer than the worst allocate or init, so a stray late beat is caught
	localparam int TAIL_CYCLES    = 600;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [OP_W-1:0]         op;
	logic [FN_IN_W-1:0]      frame_number;
	logic                    out_valid;
	logic                    out_stall;
	logic [STATUS_W-1:0]     status;
	logic [ALLOC_FN_W-1:0]   alloc_frame_number;
	logic [ADDR_W-1:0]       alloc_address;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        cfg_data;

	int mismatch_count;
	int outstanding;
	int send_idle_pct  = 17;
	int recv_idle_pct  = 83;
	int rx_hold_left   = 0;
	int reserved_now   = 0;
	int cycle_count    = 0;

	frame_bitmap_allocator_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.op                 (op),
		.frame_number       (frame_number),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.alloc_frame_number (alloc_frame_number),
		.alloc_address      (alloc_address),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data)
	);

	frame_bitmap_allocator_scoreboard u_scoreboard (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.op                 (op),
		.frame_number       (frame_number),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.alloc_frame_number (alloc_frame_number),
		.alloc_address      (alloc_address),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.mismatch_count     (mismatch_count),
		.outstanding        (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run with a mismatch verdict once the cycle count reaches CYCLE_LIMIT
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off for a long stretch on request so
	// that the output register fills and the block backs up onto its input
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				out_stall <= 1'b1;
				rx_hold_left = rx_hold_left - 1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Offer one command beat, idling first at random; return at the edge
	// that takes it. Valid stays high into the next call if no idle is drawn.
	task automatic send_cmd(input op_t cmd, input logic [FN_IN_W-1:0] fnum);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		op           <= cmd;
		frame_number <= fnum;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and hold until every predicted beat has come back, so the
	// block is idle before the register is touched
	task automatic drain_results;
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reserved(input int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reserved_now = value;
	endtask

	// One random command. Half the frees land near the reservation edge, where
	// allocate hands frames out, so alloc and free keep interacting.
	task automatic send_random;
		int pick;
		int base;
		int lo;
		logic [FN_IN_W-1:0] fnum;
		pick = $urandom_range(99);
		fnum = FN_IN_W'($urandom);
		if (pick < 44) begin
			send_cmd(OP_ALLOC, fnum);
		end else if (pick < 88) begin
			base = (reserved_now > FRAME_COUNT) ? FRAME_COUNT : reserved_now;
			lo = (base > 16) ? base - 16 : 0;
			pick = $urandom_range(99);
			if (pick < 50)
				fnum = FN_IN_W'(lo + $urandom_range(95));
			else if (pick < 70)
				fnum = FN_IN_W'($urandom_range(FRAME_COUNT - 1));
			else if (pick >= 85) begin
				case ($urandom_range(3))
					0: fnum = '0;
					1: fnum = FN_IN_W'(FRAME_COUNT - 1);
					2: fnum = FN_IN_W'(FRAME_COUNT);
					default: fnum = '1;
				endcase
			end
			send_cmd(OP_FREE, fnum);
		end else if (pick < 94) begin
			send_cmd(OP_NOP, fnum);
		end else begin
			send_cmd(OP_INIT, fnum);
		end
	endtask

	// Settle the block, set the idle mix and reservation, re-init the map,
	// then stream random beats; optionally start the long receiver hold-off
	task automatic run_phase(input int res, input int snd_pct, input int rcv_pct,
			input int hold_at);
		int i;
		drain_results;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		write_reserved(res);
		send_cmd(OP_INIT, FN_IN_W'($urandom));
		for (i = 0; i < PHASE_ITEMS; i++) begin
			send_random;
			if (i == hold_at)
				rx_hold_left = RX_HOLD_CYCLES;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = OP_ALLOC;
		frame_number = '0;
		out_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Empty map after reset: lowest-first hand-out, reuse of a freed
		// frame, freeing a frame that is already free, out-of-range frees
		// and the no-op
		send_cmd(OP_ALLOC, '0);
		send_cmd(OP_ALLOC, '1);
		send_cmd(OP_FREE, '0);
		send_cmd(OP_ALLOC, '0);
		send_cmd(OP_FREE, FN_IN_W'(FRAME_COUNT - 1));
		send_cmd(OP_FREE, FN_IN_W'(FRAME_COUNT));
		send_cmd(OP_FREE, '1);
		send_cmd(OP_NOP, '1);
		send_cmd(OP_FREE, FN_IN_W'(1));
		send_cmd(OP_ALLOC, '0);

		// Whole map reserved: memory full, then the top frame freed and
		// handed back at the highest address
		drain_results;
		write_reserved(FRAME_COUNT);
		send_cmd(OP_INIT, '0);
		send_cmd(OP_ALLOC, '0);
		send_cmd(OP_FREE, FN_IN_W'(FRAME_COUNT - 1));
		send_cmd(OP_ALLOC, '0);
		send_cmd(OP_ALLOC, '0);

		// Reservation beyond the map saturates
		drain_results;
		write_reserved(32767);
		send_cmd(OP_INIT, '1);
		send_cmd(OP_ALLOC, '0);
		send_cmd(OP_FREE, '0);
		send_cmd(OP_ALLOC, '0);

		// Random phases: sender light and receiver heavy idling, then the
		// reverse, then none; the long hold-off falls in the unthrottled part
		run_phase(0, 17, 83, -1);
		run_phase($urandom_range(1, 700), 17, 83, -1);
		run_phase(FRAME_COUNT, 83, 17, -1);
		run_phase(32767, 83, 17, -1);
		run_phase($urandom_range(0, 300), 0, 0, 12);
		run_phase(FRAME_COUNT - 1, 0, 0, -1);

		drain_results;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== frame_bitmap_allocator_top.f =====
rtl/core/fba_pkg.sv
rtl/core/fba_ram.sv
rtl/core/fba_word_scan.sv
rtl/core/frame_bitmap_allocator_top.sv
tb/sv/frame_bitmap_allocator_scoreboard.sv
tb/sv/frame_bitmap_allocator_top_tb.sv
